// File: src/task_ready_queue_with_deadline_insert_unit_assert.svh
// Assertion macros for the task ready queue with deadline insert
`ifndef TASK_READY_QUEUE_WITH_DEADLINE_INSERT_UNIT_ASSERT_SVH
`define TASK_READY_QUEUE_WITH_DEADLINE_INSERT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trq assertion failed");
// next-cycle implication
`define TRQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trq assertion failed");
`else
`define TRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TRQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: src/trq_pkg.sv
// Types, codes and sizes shared by the task ready queue files
package trq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int DEADLINE_BITS = 32;
    localparam int IDX_W         = $clog2(QUEUE_DEPTH);
    localparam int OCC_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] RT_LEVEL_RESET = 8'd128;

    localparam logic [2:0] ST_READY     = 3'd0;
    localparam logic [2:0] ST_RUNNING   = 3'd1;
    localparam logic [2:0] ST_BLK_SEND  = 3'd2;
    localparam logic [2:0] ST_SUSPENDED = 3'd3;

    typedef enum logic [2:0] {
        MODE_PUSH_HEAD = 3'd0,
        MODE_PUSH_TAIL = 3'd1,
        MODE_POP_HEAD  = 3'd2,
        MODE_POP_TAIL  = 3'd3,
        MODE_REMOVE    = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_NOT_FOUND = 3'd2,
        STAT_PRIO      = 3'd3,
        STAT_FULL      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ACT_HOLD   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2
    } cell_act_t;

    typedef enum logic [1:0] {
        HIT_ALL      = 2'd0,
        HIT_FREE     = 2'd1,
        HIT_DEADLINE = 2'd2,
        HIT_ID       = 2'd3
    } hit_mode_t;

    typedef struct packed {
        logic [7:0]               task_id;
        logic [2:0]               task_state;
        logic [DEADLINE_BITS-1:0] deadline;
    } entry_t;

    typedef struct packed {
        cell_act_t act;
        hit_mode_t hit_mode;
        entry_t    key;
    } cell_cmd_t;

endpackage

// File: src/trq_cell.sv
// One queue cell: holds an entry, matches it against the key and shifts
module trq_cell
    import trq_pkg::*;
(
    input  logic      clk,
    input  cell_cmd_t cmd,
    input  logic      occupied,
    input  entry_t    left_entry,
    input  entry_t    right_entry,
    input  logic      found_in,
    output entry_t    entry,
    output logic      found_out,
    output logic      first_hit
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   hit;
    logic   earlier;

    assign earlier = entry_reg.deadline < cmd.key.deadline;

    always_comb
    begin
        unique case (cmd.hit_mode)
            HIT_ALL:      hit = 1'b1;
            HIT_FREE:     hit = !occupied;
            HIT_DEADLINE: hit = !occupied || !earlier;
            HIT_ID:       hit = occupied && (entry_reg.task_id == cmd.key.task_id);
            default:      hit = 1'b0;
        endcase
    end

    assign found_out = found_in || hit;
    assign first_hit = hit && !found_in;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.act)
            ACT_INSERT:
            begin
                // cells past the insert point take their left neighbour
                if (found_in)
                    entry_next = left_entry;
                else if (hit)
                    entry_next = cmd.key;
            end
            ACT_REMOVE:
            begin
                // the removed cell and all after it take their right neighbour
                if (found_out)
                    entry_next = right_entry;
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: src/task_ready_queue_with_deadline_insert_unit.sv
// Top level of the earliest-deadline-first task ready queue
// A result is registered and shown the cycle after its input transaction is accepted.
// One op per cycle unless m_tready stalls; every cell compares and shifts in parallel.
// The search is a ripple of found flags along the row of QUEUE_DEPTH cells.
// Reset: occupancy clears to zero and the real-time level to 128 at once;
// cell contents are not reset and are never read before written.
module task_ready_queue_with_deadline_insert_unit
    import trq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,   // realtime_priority_level
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,       // task_id[7:0], task_state[10:8], rt_task[11],
                                       // priority_req[19:12], deadline[51:20], zero pad
    input  logic [2:0]  s_tuser,       // mode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata        // status[2:0], result_task[10:3],
                                       // result_state[13:11], result_valid[14], zero pad
);

    `include "task_ready_queue_with_deadline_insert_unit_assert.svh"

    // input field unpacking
    logic [7:0]               in_id;
    logic [2:0]               in_state;
    logic                     in_rt;
    logic [7:0]               in_prio;
    logic [DEADLINE_BITS-1:0] in_dl;
    mode_t                    in_mode;

    assign in_id    = s_tdata[7:0];
    assign in_state = s_tdata[10:8];
    assign in_rt    = s_tdata[11];
    assign in_prio  = s_tdata[19:12];
    assign in_dl    = DEADLINE_BITS'(s_tdata[51:20]);
    assign in_mode  = mode_t'(s_tuser);

    // control state
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic [7:0]       level_reg;

    // output register
    logic       m_valid_reg;
    status_t    status_reg;
    logic [7:0] rtask_reg;
    logic [2:0] rstate_reg;
    logic       rvalid_reg;

    status_t    status_next;
    logic [7:0] rtask_next;
    logic [2:0] rstate_next;
    logic       rvalid_next;

    logic accept;
    logic occ_full;
    logic occ_empty;

    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign occ_full  = occ_reg == OCC_W'(QUEUE_DEPTH);
    assign occ_empty = occ_reg == '0;

    // broadcast command to the cell row
    cell_cmd_t  cmd;
    hit_mode_t  hit_mode;
    cell_act_t  act;
    logic [2:0] ns_head;
    logic [2:0] ns_tail;

    // suspended tasks keep their state; push tail also keeps blocked-on-send
    assign ns_head = (in_state == ST_SUSPENDED) ? in_state : ST_READY;
    assign ns_tail = (in_state == ST_SUSPENDED || in_state == ST_BLK_SEND)
                     ? in_state : ST_READY;

    always_comb
    begin
        unique case (in_mode)
            MODE_PUSH_HEAD: hit_mode = HIT_ALL;
            MODE_PUSH_TAIL: hit_mode = in_rt ? HIT_DEADLINE : HIT_FREE;
            MODE_POP_HEAD:  hit_mode = HIT_ALL;
            MODE_REMOVE:    hit_mode = HIT_ID;
            default:        hit_mode = HIT_ALL;
        endcase
    end

    assign cmd.act              = act;
    assign cmd.hit_mode         = hit_mode;
    assign cmd.key.task_id      = in_id;
    assign cmd.key.task_state   = (in_mode == MODE_PUSH_HEAD) ? ns_head : ns_tail;
    assign cmd.key.deadline     = in_dl;

    // the row of cells
    entry_t                 cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH:0]   found;
    logic [QUEUE_DEPTH-1:0] first_hit;
    logic [QUEUE_DEPTH-1:0] occupied;

    assign found[0] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;

        assign occupied[i] = OCC_W'(i) < occ_reg;

        if (i == 0)
        begin : g_first
            assign left_e = cmd.key;
        end
        else
        begin : g_mid_l
            assign left_e = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_e = cell_entry[i];
        end
        else
        begin : g_mid_r
            assign right_e = cell_entry[i+1];
        end

        trq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occupied    (occupied[i]),
            .left_entry  (left_e),
            .right_entry (right_e),
            .found_in    (found[i]),
            .entry       (cell_entry[i]),
            .found_out   (found[i+1]),
            .first_hit   (first_hit[i])
        );
    end

    // gather the first matching cell, and the tail cell for pop tail
    entry_t           sel_entry;
    entry_t           tail_entry;
    logic [IDX_W-1:0] tail_idx;

    always_comb
    begin
        sel_entry = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (first_hit[i])
                sel_entry = sel_entry | cell_entry[i];
        end
    end

    assign tail_idx   = IDX_W'(occ_reg - 1'b1);
    assign tail_entry = cell_entry[tail_idx];

    // operation decode
    always_comb
    begin
        act         = ACT_HOLD;
        occ_next    = occ_reg;
        status_next = STAT_OK;
        rtask_next  = '0;
        rstate_next = '0;
        rvalid_next = 1'b0;
        if (accept)
        begin
            unique case (in_mode)
                MODE_PUSH_HEAD:
                begin
                    if (occ_full)
                        status_next = STAT_FULL;
                    else
                    begin
                        act         = ACT_INSERT;
                        occ_next    = OCC_W'(occ_reg + 1'b1);
                        rtask_next  = in_id;
                        rstate_next = ns_head;
                        rvalid_next = 1'b1;
                    end
                end
                MODE_PUSH_TAIL:
                begin
                    // full check comes before the priority check
                    if (occ_full)
                        status_next = STAT_FULL;
                    else if (in_rt && !occ_empty && (in_prio != level_reg))
                        status_next = STAT_PRIO;
                    else
                    begin
                        act         = ACT_INSERT;
                        occ_next    = OCC_W'(occ_reg + 1'b1);
                        rtask_next  = in_id;
                        rstate_next = ns_tail;
                        rvalid_next = 1'b1;
                    end
                end
                MODE_POP_HEAD:
                begin
                    if (occ_empty)
                        status_next = STAT_EMPTY;
                    else
                    begin
                        act         = ACT_REMOVE;
                        occ_next    = OCC_W'(occ_reg - 1'b1);
                        rtask_next  = cell_entry[0].task_id;
                        rstate_next = (cell_entry[0].task_state == ST_BLK_SEND)
                                      ? ST_READY : ST_RUNNING;
                        rvalid_next = 1'b1;
                    end
                end
                MODE_POP_TAIL:
                begin
                    // drop the tail by count alone; no cell moves
                    if (occ_empty)
                        status_next = STAT_EMPTY;
                    else
                    begin
                        occ_next    = OCC_W'(occ_reg - 1'b1);
                        rtask_next  = tail_entry.task_id;
                        rstate_next = tail_entry.task_state;
                        rvalid_next = 1'b1;
                    end
                end
                MODE_REMOVE:
                begin
                    if (occ_empty)
                        status_next = STAT_EMPTY;
                    else if (!found[QUEUE_DEPTH])
                        status_next = STAT_NOT_FOUND;
                    else
                    begin
                        act         = ACT_REMOVE;
                        occ_next    = OCC_W'(occ_reg - 1'b1);
                        rtask_next  = sel_entry.task_id;
                        rstate_next = first_hit[0] ? ST_READY : sel_entry.task_state;
                        rvalid_next = 1'b1;
                    end
                end
                default:
                begin
                    // unused modes: no change, plain ok result
                    status_next = STAT_OK;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg     <= '0;
            level_reg   <= RT_LEVEL_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (cfg_wr_en)
                level_reg <= cfg_wr_data;
            if (accept)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // result payload: hold until the next accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            rtask_reg  <= rtask_next;
            rstate_reg <= rstate_next;
            rvalid_reg <= rvalid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, rvalid_reg, rstate_reg, rtask_reg, status_reg};

    // assertions
    logic full_push;
    logic live_pop;

    assign full_push = accept && occ_full
                       && (in_mode == MODE_PUSH_HEAD || in_mode == MODE_PUSH_TAIL);
    assign live_pop  = accept && !occ_empty
                       && (in_mode == MODE_POP_HEAD || in_mode == MODE_POP_TAIL);

    `TRQ_ASSERT_IMP(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= OCC_W'(QUEUE_DEPTH))
    `TRQ_ASSERT_NXT(a_full_holds, clk, rst_n, full_push, occ_reg == $past(occ_reg) && status_reg == STAT_FULL)
    `TRQ_ASSERT_IMP(a_valid_ok, clk, rst_n, m_valid_reg && rvalid_reg, status_reg == STAT_OK)
    `TRQ_ASSERT_NXT(a_pop_count, clk, rst_n, live_pop, occ_reg == OCC_W'($past(occ_reg) - 1'b1) && rvalid_reg)

endmodule
